>>> design/gtp_pkg.sv
// ----------------------------------------------------------------------------
// gtp_pkg
// Shared types and constants of the Goertzel tone power block: field widths,
// register indexes, datapath operations and the command and status words.
// ----------------------------------------------------------------------------
package gtp_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int BLOCK_BITS  = 13;
  localparam int MAX_BLOCK   = 4096;
  localparam int STATE_BITS  = 48;
  localparam int PROD_BITS   = 64;
  localparam int POWER_BITS  = 40;
  localparam int HALF_BITS   = 20;
  localparam int ACC_BITS    = 81;
  localparam int DIV_BITS    = 25;
  localparam int COUNT_BITS  = $clog2(POWER_BITS);
  localparam int INDEX_BITS  = 2;

  localparam logic signed [STATE_BITS-1:0] STATE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [STATE_BITS-1:0] STATE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
  localparam logic [POWER_BITS-1:0]        POWER_MAX = {POWER_BITS{1'b1}};

  typedef enum logic [INDEX_BITS-1:0] {
    REG_COEFFICIENT  = 2'd0,
    REG_COSINE       = 2'd1,
    REG_SINE         = 2'd2,
    REG_BLOCK_LENGTH = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_COEF,
    OP_UPDATE,
    OP_MUL_COS,
    OP_RE,
    OP_MUL_SIN,
    OP_IM,
    OP_MAG,
    OP_SQ,
    OP_CHECK,
    OP_DIV,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    SQ_RE_LL,
    SQ_RE_HL,
    SQ_RE_HH,
    SQ_IM_LL,
    SQ_IM_HL,
    SQ_IM_HH,
    SQ_BLOCK
  } sq_step_t;

  typedef struct packed {
    logic     load;
    op_t      op;
    sq_step_t step;
  } gtp_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } gtp_status_t;

endpackage

>>> design/gtp_ctrl.sv
// ----------------------------------------------------------------------------
// gtp_ctrl
// Sequencer of the Goertzel tone power block: accepts sample words, steps the
// datapath through the recursion and, on the last sample, through the power
// calculation and the bit-serial division.
// ----------------------------------------------------------------------------
module gtp_ctrl import gtp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_ready,
  input  gtp_status_t status,
  output gtp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPDATE,
    S_MUL_COS,
    S_RE,
    S_MUL_SIN,
    S_IM,
    S_MAG,
    S_SQ,
    S_CHECK,
    S_DIV,
    S_EMIT
  } state_t;

  state_t                state, state_next;
  sq_step_t              step, step_next;
  logic [COUNT_BITS-1:0] count, count_next;

  assign sample_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    count_next = count;
    cmd.load   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.step   = step;
    unique case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.load   = 1'b1;
          cmd.op     = OP_MUL_COEF;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.op     = OP_UPDATE;
        state_next = status.last ? S_MUL_COS : S_IDLE;
      end
      S_MUL_COS: begin
        cmd.op     = OP_MUL_COS;
        state_next = S_RE;
      end
      S_RE: begin
        cmd.op     = OP_RE;
        state_next = S_MUL_SIN;
      end
      S_MUL_SIN: begin
        cmd.op     = OP_MUL_SIN;
        state_next = S_IM;
      end
      S_IM: begin
        cmd.op     = OP_IM;
        state_next = S_MAG;
      end
      S_MAG: begin
        cmd.op     = OP_MAG;
        step_next  = SQ_RE_LL;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (step == SQ_BLOCK) begin
          state_next = S_CHECK;
        end else begin
          step_next = sq_step_t'(step + 3'd1);
        end
      end
      S_CHECK: begin
        cmd.op     = OP_CHECK;
        count_next = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op     = OP_DIV;
        count_next = count + COUNT_BITS'(1);
        if (count == COUNT_BITS'(POWER_BITS - 1)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= SQ_RE_LL;
      count <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      count <= count_next;
    end
  end

endmodule

>>> design/gtp_datapath.sv
// ----------------------------------------------------------------------------
// gtp_datapath
// Registers, shared recursion multiplier, squaring multiplier with its
// accumulator, restoring divider and the output word register.
// ----------------------------------------------------------------------------
module gtp_datapath import gtp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  gtp_cmd_t                      cmd,
  output gtp_status_t                   status,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last,
  input  logic                          cfg_write,
  input  logic [INDEX_BITS-1:0]         cfg_index,
  input  logic [COEF_BITS-1:0]          cfg_data,
  output logic                          power_valid,
  input  logic                          power_ready,
  output logic [POWER_BITS-1:0]         power
);

  logic signed [COEF_BITS-1:0]   coefficient, cosine, sine;
  logic [BLOCK_BITS-1:0]         block_length;
  logic signed [STATE_BITS-1:0]  delay_one, delay_two;
  logic signed [SAMPLE_BITS-1:0] sample_reg;
  logic                          last_reg;
  logic signed [PROD_BITS-1:0]   prod_reg;
  logic signed [STATE_BITS-1:0]  s0_reg;
  logic signed [49:0]            re_reg, im_reg;
  logic [POWER_BITS-1:0]         mr, mi;
  logic                          big;
  logic [ACC_BITS-1:0]           acc;
  logic [DIV_BITS-1:0]           d_reg, rem;
  logic [POWER_BITS-1:0]         qsh;
  logic                          sat;

  // recursion multiplier
  logic signed [COEF_BITS-1:0] mul_a;
  logic signed [PROD_BITS-1:0] mul_prod;
  always_comb begin
    priority case (cmd.op)
      OP_MUL_COS: mul_a = cosine;
      OP_MUL_SIN: mul_a = sine;
      default:    mul_a = coefficient;
    endcase
  end
  assign mul_prod = PROD_BITS'(mul_a) * PROD_BITS'(delay_one);

  // rounding shifts
  logic signed [PROD_BITS-1:0] rnd14, rnd15;
  logic signed [49:0]          r14;
  logic signed [48:0]          r15;
  assign rnd14 = (prod_reg + 64'sd8192) >>> 14;
  assign rnd15 = (prod_reg + 64'sd16384) >>> 15;
  assign r14   = $signed(rnd14[49:0]);
  assign r15   = $signed(rnd15[48:0]);

  logic signed [51:0]           s0_wide;
  logic signed [STATE_BITS-1:0] s0;
  assign s0_wide = 52'(sample_reg) + 52'(r14) - 52'(delay_two);
  always_comb begin
    priority if (s0_wide > 52'(STATE_MAX)) begin
      s0 = STATE_MAX;
    end else if (s0_wide < 52'(STATE_MIN)) begin
      s0 = STATE_MIN;
    end else begin
      s0 = s0_wide[STATE_BITS-1:0];
    end
  end

  logic [49:0] re_abs, im_abs;
  assign re_abs = re_reg[49] ? 50'(-re_reg) : 50'(re_reg);
  assign im_abs = im_reg[49] ? 50'(-im_reg) : 50'(im_reg);

  logic [BLOCK_BITS-1:0] n_eff;
  always_comb begin
    priority if (block_length == '0) begin
      n_eff = BLOCK_BITS'(1);
    end else if (block_length > BLOCK_BITS'(MAX_BLOCK)) begin
      n_eff = BLOCK_BITS'(MAX_BLOCK);
    end else begin
      n_eff = block_length;
    end
  end

  // squaring multiplier, partial products of the two magnitudes and N squared
  logic [HALF_BITS-1:0]   sq_a, sq_b;
  logic [2*HALF_BITS-1:0] sq_prod;
  logic [ACC_BITS-1:0]    acc_add;
  always_comb begin
    sq_a    = mr[HALF_BITS-1:0];
    sq_b    = mr[HALF_BITS-1:0];
    acc_add = ACC_BITS'(sq_prod);
    unique case (cmd.step)
      SQ_RE_LL: begin
        sq_a = mr[HALF_BITS-1:0];
        sq_b = mr[HALF_BITS-1:0];
      end
      SQ_RE_HL: begin
        sq_a    = mr[POWER_BITS-1:HALF_BITS];
        sq_b    = mr[HALF_BITS-1:0];
        acc_add = ACC_BITS'(sq_prod) << (HALF_BITS + 1);
      end
      SQ_RE_HH: begin
        sq_a    = mr[POWER_BITS-1:HALF_BITS];
        sq_b    = mr[POWER_BITS-1:HALF_BITS];
        acc_add = ACC_BITS'(sq_prod) << (2 * HALF_BITS);
      end
      SQ_IM_LL: begin
        sq_a = mi[HALF_BITS-1:0];
        sq_b = mi[HALF_BITS-1:0];
      end
      SQ_IM_HL: begin
        sq_a    = mi[POWER_BITS-1:HALF_BITS];
        sq_b    = mi[HALF_BITS-1:0];
        acc_add = ACC_BITS'(sq_prod) << (HALF_BITS + 1);
      end
      SQ_IM_HH: begin
        sq_a    = mi[POWER_BITS-1:HALF_BITS];
        sq_b    = mi[POWER_BITS-1:HALF_BITS];
        acc_add = ACC_BITS'(sq_prod) << (2 * HALF_BITS);
      end
      SQ_BLOCK: begin
        sq_a = HALF_BITS'(n_eff);
        sq_b = HALF_BITS'(n_eff);
      end
      default: begin
        sq_a = '0;
        sq_b = '0;
      end
    endcase
  end
  assign sq_prod = sq_a * sq_b;

  // restoring division step
  logic [DIV_BITS:0] div_t;
  logic              div_ge;
  assign div_t  = {rem, qsh[POWER_BITS-1]};
  assign div_ge = (div_t >= {1'b0, d_reg});

  always_ff @(posedge clk) begin
    if (rst) begin
      coefficient  <= '0;
      cosine       <= 16'sd32767;
      sine         <= '0;
      block_length <= BLOCK_BITS'(205);
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_COEFFICIENT:  coefficient  <= $signed(cfg_data);
        REG_COSINE:       cosine       <= $signed(cfg_data);
        REG_SINE:         sine         <= $signed(cfg_data);
        REG_BLOCK_LENGTH: block_length <= cfg_data[BLOCK_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_one <= '0;
      delay_two <= '0;
    end else if (cmd.op == OP_UPDATE && !last_reg) begin
      delay_two <= delay_one;
      delay_one <= s0;
    end else if (cmd.op == OP_EMIT) begin
      delay_one <= '0;
      delay_two <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_reg <= sample;
      last_reg   <= last;
    end
    unique case (cmd.op)
      OP_MUL_COEF, OP_MUL_COS, OP_MUL_SIN: prod_reg <= mul_prod;
      OP_UPDATE: s0_reg <= s0;
      OP_RE:     re_reg <= 50'(s0_reg) - 50'(r15);
      OP_IM:     im_reg <= -50'(r15);
      OP_MAG: begin
        mr  <= re_abs[POWER_BITS-1:0];
        mi  <= im_abs[POWER_BITS-1:0];
        big <= (re_abs[49:POWER_BITS] != '0) || (im_abs[49:POWER_BITS] != '0);
        acc <= '0;
      end
      OP_SQ: begin
        if (cmd.step == SQ_BLOCK) begin
          d_reg <= sq_prod[DIV_BITS-1:0];
        end else begin
          acc <= acc + acc_add;
        end
      end
      OP_CHECK: begin
        sat <= big || (acc[ACC_BITS-1:POWER_BITS-1] >= 42'(d_reg));
        rem <= acc[POWER_BITS+DIV_BITS-2:POWER_BITS-1];
        qsh <= {acc[POWER_BITS-2:0], 1'b0};
      end
      OP_DIV: begin
        rem <= div_ge ? DIV_BITS'(div_t - {1'b0, d_reg}) : div_t[DIV_BITS-1:0];
        qsh <= {qsh[POWER_BITS-2:0], div_ge};
      end
      OP_NONE, OP_EMIT: ;
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      power_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      power_valid <= 1'b1;
    end else if (power_ready) begin
      power_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      power <= sat ? POWER_MAX : qsh;
    end
  end

  assign status.last     = last_reg;
  assign status.out_free = !power_valid || power_ready;

endmodule

>>> design/goertzel_tone_power.sv
// ----------------------------------------------------------------------------
// goertzel_tone_power
// Goertzel single-tone power detector with a configuration write port.
// ----------------------------------------------------------------------------
// A sample word without last is accepted together with the coefficient
// product on the shared recursion multiplier, and the delay line is updated
// in the next cycle, before the next word is accepted. After a sample word
// with last, the next one is accepted only after the cosine and sine products
// on the same multiplier, seven steps of the squaring multiplier and a
// 40-step restoring divider by N squared. The power word then waits in an
// output register, and new samples are taken while it waits; a following
// power word is held back only while the previous one has not been taken.
// Configuration writes are always accepted and take effect at once.
module goertzel_tone_power import gtp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [INDEX_BITS-1:0]         cfg_index,
  input  logic [COEF_BITS-1:0]          cfg_data,
  output logic                          power_valid,
  input  logic                          power_ready,
  output logic [POWER_BITS-1:0]         power
);

  gtp_cmd_t    cmd;
  gtp_status_t status;

  assign cfg_ready = 1'b1;

  gtp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  gtp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .sample      (sample),
    .last        (last),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .power_valid (power_valid),
    .power_ready (power_ready),
    .power       (power)
  );

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for goertzel_tone_power. Sample words are driven over a
// valid/ready channel and the recursion and power arithmetic are worked out
// alongside in fixed point. Each power word taken from the block is compared
// with the oldest outstanding prediction. A directed run over the extremes is
// followed by random blocks under several register settings and idling
// patterns, including one long hold-off on the power channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import gtp_pkg::*;

  localparam int ITEMS       = 850;
  localparam int SEG_ITEMS   = 70;
  localparam int SETTLE      = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;

  class tone_power_calc;
    logic signed [COEF_BITS-1:0]  coef;
    logic signed [COEF_BITS-1:0]  cos_q;
    logic signed [COEF_BITS-1:0]  sin_q;
    logic [BLOCK_BITS-1:0]        blk_len;
    logic signed [STATE_BITS-1:0] s1;
    logic signed [STATE_BITS-1:0] s2;
    logic [POWER_BITS-1:0]        power_due[$];
    int                           errors;

    function new();
      coef    = '0;
      cos_q   = 16'sh7fff;
      sin_q   = '0;
      blk_len = 13'd205;
      s1      = '0;
      s2      = '0;
      errors  = 0;
    endfunction

    function void set_register(reg_index_t idx, logic [COEF_BITS-1:0] v);
      case (idx)
        REG_COEFFICIENT:  coef    = v;
        REG_COSINE:       cos_q   = v;
        REG_SINE:         sin_q   = v;
        REG_BLOCK_LENGTH: blk_len = v[BLOCK_BITS-1:0];
        default:          ;
      endcase
    endfunction

    // shift right with rounding half towards +inf
    function longint round_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function logic [POWER_BITS-1:0] tone_power(longint re, longint im);
      logic [63:0]  mr;
      logic [63:0]  mi;
      logic [127:0] num;
      logic [127:0] div;
      logic [127:0] quo;
      mr = (re < 0) ? -re : re;
      mi = (im < 0) ? -im : im;
      if (mr >= (64'd1 << POWER_BITS) || mi >= (64'd1 << POWER_BITS))
        return POWER_MAX;
      num = ({64'd0, mr} * mr + {64'd0, mi} * mi) << 1;
      if (blk_len == 0)
        div = 128'd1;
      else if (blk_len > MAX_BLOCK)
        div = 128'(MAX_BLOCK);
      else
        div = 128'(blk_len);
      div = div * div;
      quo = num / div;
      if (quo > POWER_MAX)
        return POWER_MAX;
      return quo[POWER_BITS-1:0];
    endfunction

    function void take_sample(logic signed [SAMPLE_BITS-1:0] x, logic fin);
      longint acc;
      longint re;
      longint im;
      acc = longint'(x) + round_shift(longint'(coef) * longint'(s1), 14) - longint'(s2);
      if (acc > longint'(STATE_MAX))
        acc = longint'(STATE_MAX);
      else if (acc < longint'(STATE_MIN))
        acc = longint'(STATE_MIN);
      if (!fin) begin
        s2 = s1;
        s1 = acc[STATE_BITS-1:0];
        return;
      end
      re = acc - round_shift(longint'(s1) * longint'(cos_q), 15);
      im = -round_shift(longint'(s1) * longint'(sin_q), 15);
      power_due.push_back(tone_power(re, im));
      s1 = '0;
      s2 = '0;
    endfunction

    function void check_power(logic [POWER_BITS-1:0] got);
      logic [POWER_BITS-1:0] want;
      if (power_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected power word %0d", got);
        return;
      end
      want = power_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("power mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          sample_valid = 1'b0;
  logic                          sample_ready;
  logic signed [SAMPLE_BITS-1:0] sample       = '0;
  logic                          last         = 1'b0;
  logic                          cfg_valid    = 1'b0;
  logic                          cfg_ready;
  reg_index_t                    cfg_index    = REG_COEFFICIENT;
  logic [COEF_BITS-1:0]          cfg_data     = '0;
  logic                          power_valid;
  logic                          power_ready  = 1'b0;
  logic [POWER_BITS-1:0]         power;

  tone_power_calc calc = new();
  int             tx_idle_pct = 13;
  int             rx_idle_pct = 74;
  int             sent = 0;
  bit             squeeze = 1'b0;
  bit             squeezed = 1'b0;

  goertzel_tone_power i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .power_valid  (power_valid),
    .power_ready  (power_ready),
    .power        (power)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x, input logic fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= x;
    last         <= fin;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    calc.take_sample(x, fin);
    sent++;
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [COEF_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    calc.set_register(idx, v);
  endtask

  task automatic configure(input logic [15:0] coef_w, cos_w, sin_w, len_w);
    write_reg(REG_COEFFICIENT, coef_w);
    write_reg(REG_COSINE, cos_w);
    write_reg(REG_SINE, sin_w);
    write_reg(REG_BLOCK_LENGTH, len_w);
    cfg_valid <= 1'b0;
  endtask

  // wait for every power word, then let a trailing sample word finish
  task automatic quiesce();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (calc.power_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(7))
      0:       v = 16'h7fff;
      1:       v = 16'h8000;
      2, 3:    v = {{8{v[7]}}, v[7:0]};
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] pick_trig();
    case ($urandom_range(5))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_length();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd4096;
      3:       return 16'd4097;
      4:       return 16'hffff;
      5:       return 16'($urandom);
      default: return 16'($urandom_range(300, 2));
    endcase
  endfunction

  task automatic send_block();
    int len;
    case ($urandom_range(19))
      0:          len = $urandom_range(80, 41);
      1, 2, 3:    len = $urandom_range(40, 9);
      default:    len = $urandom_range(8, 1);
    endcase
    for (int i = 1; i < len; i++)
      send_sample(pick_sample(), 1'b0);
    send_sample(pick_sample(), 1'b1);
  endtask

  // power channel: check each word taken, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (power_valid && power_ready)
        calc.check_power(power);
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        power_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        power_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((sample_valid && sample_ready) || (cfg_valid && cfg_ready) ||
          (power_valid && power_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int seg_start;
    int mode;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, then the register and sample extremes
    send_sample(16'sh7fff, 1'b1);
    quiesce();
    configure(16'h7fff, 16'h8000, 16'h7fff, 16'd0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);
    quiesce();
    configure(16'h8000, 16'h0000, 16'h8000, 16'd4096);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh0000, 1'b1);
    quiesce();
    configure(16'h0000, 16'h7fff, 16'h0000, 16'hffff);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh0001, 1'b1);
    send_sample(16'shffff, 1'b1);
    quiesce();
    configure(16'h4000, 16'h5a82, 16'h5a82, 16'd4097);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b0);
    send_sample(16'sd200, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd5, 1'b1);
    quiesce();
    configure(16'hc000, 16'ha57e, 16'h5a82, 16'd1);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd3, 1'b1);

    // random blocks under changing settings and idling
    for (int seg = 0; sent < ITEMS; seg++) begin
      mode = (seg / 4 > 2) ? 2 : seg / 4;
      quiesce();
      case (mode)
        0:       begin tx_idle_pct = 13; rx_idle_pct = 74; end
        1:       begin tx_idle_pct = 74; rx_idle_pct = 13; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      configure(16'($urandom), pick_trig(), pick_trig(), pick_length());
      if (mode == 2)
        squeeze = 1'b1;
      seg_start = sent;
      while (sent - seg_start < SEG_ITEMS && sent < ITEMS)
        send_block();
    end

    sample_valid <= 1'b0;
    @(posedge clk);
    while (calc.power_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (calc.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
